// ===== sv/pfa_pkg.sv =====
`default_nettype none

package pfa_pkg;

	// Field widths of the words on the two channels and of the registers
	localparam int SIZE_W    = 16;
	localparam int SEL_W     = 4;
	localparam int MODE_W    = 2;
	localparam int SCAN_W    = 5;
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;

	// Opcodes
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_ALLOC = 1'b1;

	// Placement policies
	localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
	localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

	// Register indexes, taken from paddr[2]
	localparam int   REG_SEL_BIT  = 2;
	localparam logic REG_FIT_MODE = 1'b0;
	localparam logic REG_PARTS    = 1'b1;

	typedef struct packed {
		logic              opcode;
		logic [SEL_W-1:0]  part_select;
		logic [SIZE_W-1:0] size_value;
	} req_word_t;

	typedef struct packed {
		logic              granted;
		logic [SEL_W-1:0]  granted_index;
		logic [SIZE_W-1:0] free_before;
		logic [SIZE_W-1:0] free_after;
	} rsp_word_t;

	// Controller to datapath
	typedef struct packed {
		logic load;    // write the table at the accepted word's index
		logic start;   // latch the request, clear the scan
		logic scan;    // issue one table read, advance the counter
		logic commit;  // charge the pick, load the result register
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic issue_done;  // every entry up to the limit has been read
		logic cmp_busy;    // a read is still in the compare stage
	} sts_t;

endpackage

`default_nettype wire

// ===== sv/pfa_regs.sv =====
`default_nettype none

module pfa_regs import pfa_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready,
	output logic      [MODE_W-1:0]  fit_mode,
	output logic      [SCAN_W-1:0]  parts_in_use
);

	logic [MODE_W-1:0] fit_mode_q;
	logic [SCAN_W-1:0] parts_q;
	logic              wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q <= '0;
			parts_q    <= '0;
		end else if (wr_en) begin
			unique case (paddr[REG_SEL_BIT])
				REG_FIT_MODE: fit_mode_q <= pwdata[MODE_W-1:0];
				REG_PARTS:    parts_q    <= pwdata[SCAN_W-1:0];
				default:      ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[REG_SEL_BIT])
			REG_FIT_MODE: prdata = {{(PDATA_W-MODE_W){1'b0}}, fit_mode_q};
			REG_PARTS:    prdata = {{(PDATA_W-SCAN_W){1'b0}}, parts_q};
			default:      prdata = '0;
		endcase
	end

	assign fit_mode     = fit_mode_q;
	assign parts_in_use = parts_q;

endmodule

`default_nettype wire

// ===== sv/pfa_ctrl.sv =====
`default_nettype none

module pfa_ctrl import pfa_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	input  wire logic req_opcode,
	output logic      req_stall,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_COMMIT = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       accept;
	logic       commit_ok;

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	// The result register frees up in the same cycle its word is taken
	assign commit_ok = (state_q == ST_COMMIT) && (!out_valid_q || !rsp_stall);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && req_opcode == OP_ALLOC) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (sts.issue_done && !sts.cmp_busy) state_d = ST_COMMIT;
			end
			ST_COMMIT: begin
				if (commit_ok) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.load   = accept && (req_opcode == OP_LOAD);
		cmd.start  = accept && (req_opcode == OP_ALLOC);
		cmd.scan   = (state_q == ST_SCAN) && !sts.issue_done;
		cmd.commit = commit_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (commit_ok) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = out_valid_q;

endmodule

`default_nettype wire

// ===== sv/pfa_dp.sv =====
`default_nettype none

module pfa_dp import pfa_pkg::*; #(
	parameter int NUM_PARTS = 16,
	parameter int SIZE_BITS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cmd_t              cmd,
	output sts_t                   sts,
	input  wire req_word_t         req_word,
	input  wire logic [MODE_W-1:0] fit_mode,
	input  wire logic [SCAN_W-1:0] parts_in_use,
	output rsp_word_t              rsp_word
);

	localparam int IDX_W = (NUM_PARTS > 1) ? $clog2(NUM_PARTS) : 1;
	localparam int CAP_I = (NUM_PARTS > 31) ? 31 : NUM_PARTS;
	localparam logic [SCAN_W-1:0] SCAN_CAP  = SCAN_W'(CAP_I);
	localparam logic [31:0]       PARTS_U32 = 32'(NUM_PARTS);

	logic [SIZE_BITS-1:0] free_mem [NUM_PARTS];

	logic [SIZE_BITS-1:0] req_size_q;
	logic [MODE_W-1:0]    mode_q;
	logic [SCAN_W-1:0]    limit_q;
	logic [SCAN_W-1:0]    cnt_q;
	logic                 cmp_vld_s1;
	logic [IDX_W-1:0]     idx_s1;
	logic [SIZE_BITS-1:0] rd_data_s1;
	logic                 found_q;
	logic [IDX_W-1:0]     pick_q;
	logic [SIZE_BITS-1:0] best_q;
	rsp_word_t            rsp_q;

	logic [SIZE_BITS+SIZE_W-1:0] size_ext;
	logic [SIZE_BITS-1:0]        size_in;
	logic [IDX_W+SEL_W-1:0]      wr_ext;
	logic [IDX_W+SCAN_W-1:0]     rd_ext;
	logic [IDX_W-1:0]            rd_idx;
	logic [IDX_W+SEL_W-1:0]      pick_ext;
	logic [SIZE_BITS+SIZE_W-1:0] best_ext;
	logic [SIZE_BITS+SIZE_W-1:0] diff_ext;
	logic [SIZE_BITS-1:0]        diff;
	logic [SCAN_W-1:0]           limit_d;
	logic                        load_ok;
	logic                        mem_we;
	logic [IDX_W-1:0]            mem_wa;
	logic [SIZE_BITS-1:0]        mem_wd;
	logic                        mode_ok;
	logic                        fits;
	logic                        take;

	// Size and index conversions between the word fields and table widths
	assign size_ext = {{SIZE_BITS{1'b0}}, req_word.size_value};
	assign size_in  = size_ext[SIZE_BITS-1:0];
	assign wr_ext   = {{IDX_W{1'b0}}, req_word.part_select};
	assign rd_ext   = {{IDX_W{1'b0}}, cnt_q};
	assign rd_idx   = rd_ext[IDX_W-1:0];
	assign pick_ext = {{SEL_W{1'b0}}, pick_q};
	assign diff     = best_q - req_size_q;
	assign best_ext = {{SIZE_W{1'b0}}, best_q};
	assign diff_ext = {{SIZE_W{1'b0}}, diff};

	assign limit_d = (parts_in_use > SCAN_CAP) ? SCAN_CAP : parts_in_use;
	assign load_ok = cmd.load && ({{(32-SEL_W){1'b0}}, req_word.part_select} < PARTS_U32);

	// One write port shared by loads (idle) and the charge (commit)
	assign mem_we = load_ok || (cmd.commit && found_q);
	assign mem_wa = cmd.commit ? pick_q : wr_ext[IDX_W-1:0];
	assign mem_wd = cmd.commit ? diff : size_in;

	always_ff @(posedge clk) begin
		if (mem_we) free_mem[mem_wa] <= mem_wd;
		if (cmd.scan) rd_data_s1 <= free_mem[rd_idx];
	end

	// Compare stage
	assign mode_ok = (mode_q == MODE_FIRST) || (mode_q == MODE_BEST) || (mode_q == MODE_WORST);
	assign fits    = rd_data_s1 >= req_size_q;
	assign take    = cmp_vld_s1 && mode_ok && fits &&
		(!found_q ||
		 ((mode_q == MODE_BEST)  && (rd_data_s1 < best_q)) ||
		 ((mode_q == MODE_WORST) && (rd_data_s1 > best_q)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			cmp_vld_s1 <= 1'b0;
			found_q    <= 1'b0;
		end else begin
			cmp_vld_s1 <= cmd.scan;
			if (cmd.start) begin
				cnt_q   <= '0;
				found_q <= 1'b0;
			end else begin
				if (cmd.scan) cnt_q <= cnt_q + 1'b1;
				if (take) found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			req_size_q <= size_in;
			mode_q     <= fit_mode;
			limit_q    <= limit_d;
		end
		if (cmd.scan) idx_s1 <= rd_idx;
		if (take) begin
			pick_q <= idx_s1;
			best_q <= rd_data_s1;
		end
		if (cmd.commit) begin
			rsp_q.granted       <= found_q;
			rsp_q.granted_index <= found_q ? pick_ext[SEL_W-1:0] : '0;
			rsp_q.free_before   <= found_q ? best_ext[SIZE_W-1:0] : '0;
			rsp_q.free_after    <= found_q ? diff_ext[SIZE_W-1:0] : '0;
		end
	end

	assign sts.issue_done = (cnt_q >= limit_q);
	assign sts.cmp_busy   = cmp_vld_s1;
	assign rsp_word       = rsp_q;

endmodule

`default_nettype wire

// ===== sv/partition_fit_allocator_unit.sv =====
`default_nettype none

// Partition fit allocator. The block holds a table of free sizes, one per
// memory partition. A load word (opcode 0) writes the free size of the
// partition given by part_select and returns nothing; a load beyond
// NUM_PARTS is dropped. An allocate word (opcode 1) scans partitions
// 0 .. min(parts_in_use, NUM_PARTS)-1 for one whose free size covers
// size_value, picks it by fit_mode (0 first fit, 1 best fit, 2 worst fit;
// ties go to the lowest index), charges the request against it and returns
// one result word with the index and the free size before and after. When
// nothing fits, or fit_mode is 3, the result word is all zero and the table
// is unchanged. An entry must be loaded before an allocate scans it.
// A load leaves the block idle, so the next word is accepted right after it.
// An allocate holds req_stall while it runs: the table, which has one write
// port, is read one entry a cycle; after the last read comes the compare,
// then the sequencer waits to see the compare stage empty, and then any
// charged entry is written back. The result sits in an output register;
// the block takes the next word while that result waits, and only holds a
// later allocate in its write-back cycle until the register is free.
// Configuration goes through the APB port at byte address 0 (fit_mode) and
// 4 (parts_in_use); the user is to write it only while the block is idle,
// and the block itself does not enforce this.
module partition_fit_allocator_unit import pfa_pkg::*; #(
	parameter int NUM_PARTS = 16,
	parameter int SIZE_BITS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// configuration port
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready,
	// request channel
	input  wire logic               req_valid,
	output logic                    req_stall,
	input  wire req_word_t          req_word,
	// result channel
	output logic                    rsp_valid,
	input  wire logic               rsp_stall,
	output rsp_word_t               rsp_word
);

	logic [MODE_W-1:0] fit_mode;
	logic [SCAN_W-1:0] parts_in_use;
	cmd_t              cmd;
	sts_t              sts;

	// Register file: policy and scan count
	pfa_regs u_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.fit_mode     (fit_mode),
		.parts_in_use (parts_in_use)
	);

	// Sequencer: accept, scan, write back, hand over the result word
	pfa_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_opcode (req_word.opcode),
		.req_stall  (req_stall),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	// Table memory, compare stage, pick registers and result register
	pfa_dp #(
		.NUM_PARTS (NUM_PARTS),
		.SIZE_BITS (SIZE_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.req_word     (req_word),
		.fit_mode     (fit_mode),
		.parts_in_use (parts_in_use),
		.rsp_word     (rsp_word)
	);

endmodule

`default_nettype wire

// ===== sv/pfa_checker.sv =====
`default_nettype none

module pfa_checker import pfa_pkg::*; (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               req_valid,
	input wire logic               req_stall,
	input wire req_word_t          req_word,
	input wire logic               rsp_valid,
	input wire logic               rsp_stall,
	input wire rsp_word_t          rsp_word
);

	// A stalled result word holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
		else $error("result word changed while stalled");

	// A refused request carries an all-zero result
	a_no_grant_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_word.granted |->
			rsp_word.granted_index == '0 && rsp_word.free_before == '0 &&
			rsp_word.free_after == '0)
		else $error("no-grant result carries data");

	// An accepted allocate busies the request side on the next cycle
	a_alloc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && req_word.opcode == OP_ALLOC |=> req_stall)
		else $error("allocate did not hold the request side");

	// A new result only appears after the block was busy with an allocate
	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_stall))
		else $error("result word appeared without an allocate in flight");

endmodule

bind partition_fit_allocator_unit pfa_checker u_pfa_checker (.*);

`default_nettype wire

// ===== sim/tb.sv =====
module tb import pfa_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_PARTS = 16;
	localparam int SIZE_BITS = 16;

	// fit_mode 3 names no policy: every allocate comes back without a grant
	localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;

	// Byte addresses of the two registers
	localparam logic [PADDR_W-1:0] ADDR_FIT_MODE = PADDR_W'(REG_FIT_MODE) << REG_SEL_BIT;
	localparam logic [PADDR_W-1:0] ADDR_PARTS    = PADDR_W'(REG_PARTS) << REG_SEL_BIT;

	// Slack after the worst allocate, so its write-back is done before the port
	// is touched again or the run is closed.
	localparam int SETTLE_CYCLES = 24;
	// Cycles without any accepted word before the run is called hung. The
	// limit sits well above the slowest word (gap, scan, stall) and the long
	// receiver hold.
	localparam int HANG_LIMIT = 4000;
	localparam int HOLD_CYCLES = 400;
	localparam int MAX_GAP = 12;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	logic      req_valid = 1'b0;
	logic      req_stall;
	req_word_t req_word = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	rsp_word_t rsp_word;

	// Predictor state: its own copy of the registers and the free-size table
	logic [MODE_W-1:0] cur_mode = MODE_FIRST;
	logic [SCAN_W-1:0] cur_scan = '0;
	logic [SIZE_W-1:0] part_free [NUM_PARTS];

	rsp_word_t grants_due [$];

	int  error_count = 0;
	bit  no_gaps = 1'b0;     // both sides run flat out while set
	int  hold_request = 0;   // ask the receiver for a long hold-off
	int  hold_left = 0;
	int  rsp_wait = 0;
	int  quiet_cycles = 0;

	wire req_fire = req_valid && !req_stall;
	wire rsp_fire = rsp_valid && !rsp_stall;

	always #6 clk = ~clk;

	partition_fit_allocator_unit #(
		.NUM_PARTS(NUM_PARTS),
		.SIZE_BITS(SIZE_BITS)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_word (req_word),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_word (rsp_word)
	);

	task automatic report_error(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		error_count++;
	endtask

	// Scan the table the way the block does, charge the pick and return the
	// result word it must produce. Ties keep the lowest index because a later
	// entry only wins on a strict compare.
	function automatic rsp_word_t charge_partition(input logic [SIZE_W-1:0] want);
		rsp_word_t res;
		int        limit;
		int        pick;
		bit        found;
		res = '0;
		pick = 0;
		found = 1'b0;
		limit = (cur_scan > NUM_PARTS) ? NUM_PARTS : int'(cur_scan);
		if (cur_mode != MODE_NONE) begin
			for (int k = 0; k < limit; k++) begin
				if (part_free[k] < want)
					continue;
				if (!found) begin
					pick = k;
					found = 1'b1;
					if (cur_mode == MODE_FIRST)
						break;
				end else if (cur_mode == MODE_BEST && part_free[k] < part_free[pick]) begin
					pick = k;
				end else if (cur_mode == MODE_WORST && part_free[k] > part_free[pick]) begin
					pick = k;
				end
			end
		end
		if (found) begin
			res.granted = 1'b1;
			res.granted_index = pick[SEL_W-1:0];
			res.free_before = part_free[pick];
			res.free_after = part_free[pick] - want;
			part_free[pick] = res.free_after;
		end
		return res;
	endfunction

	// Check every result word against the oldest prediction, then predict
	// for the request word taken at this edge.
	always @(posedge clk) begin
		rsp_word_t want;
		if (arst_n && rsp_fire) begin
			if (grants_due.size() == 0) begin
				report_error($sformatf("result word with nothing pending: %p", rsp_word));
			end else begin
				want = grants_due.pop_front();
				if (rsp_word.granted !== want.granted)
					report_error($sformatf("granted %0b, want %0b",
						rsp_word.granted, want.granted));
				if (rsp_word.granted_index !== want.granted_index)
					report_error($sformatf("granted_index %0d, want %0d",
						rsp_word.granted_index, want.granted_index));
				if (rsp_word.free_before !== want.free_before)
					report_error($sformatf("free_before %0d, want %0d",
						rsp_word.free_before, want.free_before));
				if (rsp_word.free_after !== want.free_after)
					report_error($sformatf("free_after %0d, want %0d",
						rsp_word.free_after, want.free_after));
			end
		end
		if (arst_n && req_fire) begin
			if (req_word.opcode == OP_LOAD)
				part_free[req_word.part_select] = req_word.size_value;
			else
				grants_due.push_back(charge_partition(req_word.size_value));
		end
	end

	// Receiver: draw a stall per result word, and serve a long hold-off
	// when a test asks for one.
	always @(posedge clk) begin
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (rsp_fire)
			rsp_wait = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
		if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else if (rsp_wait > 0) begin
			rsp_wait--;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	// Watchdog: give up when nothing moves on either channel for too long
	always @(posedge clk) begin
		if (req_fire || rsp_fire)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= HANG_LIMIT) begin
			$display("watchdog: no word accepted for %0d cycles", HANG_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Offer one request word after a random gap and return at the edge that
	// takes it. Valid stays high so a back-to-back word follows without a
	// bubble; callers that stop sending drop it themselves.
	task automatic send_word(input req_word_t w);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_word <= w;
		do @(posedge clk); while (req_stall);
	endtask

	task automatic load_part(input int sel, input logic [SIZE_W-1:0] size);
		req_word_t w;
		w.opcode = OP_LOAD;
		w.part_select = sel[SEL_W-1:0];
		w.size_value = size;
		send_word(w);
	endtask

	task automatic request(input logic [SIZE_W-1:0] size);
		req_word_t w;
		w.opcode = OP_ALLOC;
		w.part_select = SEL_W'($urandom());  // ignored by allocate, wiggle it anyway
		w.size_value = size;
		send_word(w);
	endtask

	// Drop valid and hold the sender until every pending result has come.
	// Step one edge first so the prediction for the last word is queued.
	task automatic pause_until_done();
		req_valid <= 1'b0;
		@(posedge clk);
		while (grants_due.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	// APB write: setup cycle, then access until pready; an idle cycle follows
	// so a following write never lowers and raises psel in the same step.
	task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (addr == ADDR_FIT_MODE)
			cur_mode = data[MODE_W-1:0];
		else
			cur_scan = data[SCAN_W-1:0];
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Reconfigure only once the block is idle: nothing pending and the last
	// load or write-back long finished.
	task automatic set_config(input logic [MODE_W-1:0] mode, input int scan);
		pause_until_done();
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg(ADDR_FIT_MODE, PDATA_W'(mode));
		write_reg(ADDR_PARTS, PDATA_W'(scan));
	endtask

	// Allocate with an empty scan, then fill every entry. From here on no
	// scan can touch an unwritten entry.
	task automatic test_seed_table();
		logic [SIZE_W-1:0] seed_free [NUM_PARTS];
		seed_free = '{300, 50, 300, 0, 16'hFFFF, 50, 1000, 16'h8000,
			16'h7FFF, 1, 2, 4095, 16'hAAAA, 16'h5555, 777, 300};
		request(16'd0);
		for (int i = 0; i < NUM_PARTS; i++)
			load_part(i, seed_free[i]);
	endtask

	// Walk each policy over the seeded table: ties, exact fits that leave
	// zero, full-range requests, the dead mode and oversized scan counts.
	task automatic test_each_policy();
		set_config(MODE_FIRST, NUM_PARTS);
		request(16'd0);
		request(16'd301);
		set_config(MODE_BEST, NUM_PARTS);
		request(16'd50);
		request(16'd299);
		set_config(MODE_WORST, 31);
		request(16'hFFFF);
		request(16'd1);
		set_config(MODE_NONE, 17);
		request(16'd1);
		set_config(MODE_BEST, 1);
		request(16'hFFFF);
	endtask

	// Pick a request size: small, exact hit on some entry, medium or wide
	task automatic random_request();
		logic [SIZE_W-1:0] size;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: size = SIZE_W'($urandom_range(0, 1023));
			4, 5:       size = part_free[$urandom_range(0, NUM_PARTS-1)];
			6, 7:       size = SIZE_W'($urandom_range(0, 16383));
			default:    size = SIZE_W'($urandom());
		endcase
		request(size);
	endtask

	task automatic random_load();
		logic [SIZE_W-1:0] size;
		size = $urandom_range(0, 1) ? SIZE_W'($urandom()) : SIZE_W'($urandom_range(0, 4095));
		load_part($urandom_range(0, NUM_PARTS-1), size);
	endtask

	// Random traffic in phases, each under its own settings; every fourth
	// phase runs without gaps on either side.
	task automatic test_random_phases(input int phases, input int per_phase);
		logic [MODE_W-1:0] mode;
		int                scan;
		for (int p = 0; p < phases; p++) begin
			mode = ($urandom_range(0, 9) == 0) ? MODE_NONE : MODE_W'($urandom_range(0, 2));
			case ($urandom_range(0, 5))
				0:       scan = NUM_PARTS;
				1:       scan = 31;
				2:       scan = 1;
				3:       scan = 17;
				4:       scan = $urandom_range(0, 31);
				default: scan = $urandom_range(2, NUM_PARTS);
			endcase
			set_config(mode, scan);
			no_gaps = (p % 4 == 3);
			for (int i = 0; i < per_phase; i++) begin
				if ($urandom_range(0, 99) < 35)
					random_load();
				else
					random_request();
				if ($urandom_range(0, 59) == 0)
					pause_until_done();
			end
			no_gaps = 1'b0;
		end
	endtask

	// Stop the receiver for a long stretch while the sender keeps pushing, so
	// the output register and the write-back stage fill and req_stall rises.
	task automatic test_backpressure(input int words);
		set_config(MODE_WORST, NUM_PARTS);
		for (int i = 0; i < NUM_PARTS; i++)
			load_part(i, 16'hFFFF);
		hold_request = HOLD_CYCLES;
		no_gaps = 1'b1;
		for (int i = 0; i < words; i++)
			request(SIZE_W'($urandom_range(0, 255)));
		no_gaps = 1'b0;
		pause_until_done();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_seed_table();
		test_each_policy();
		test_random_phases(12, 55);
		test_backpressure(44);

		// Close out: wait for the tail, then let any stray word show up
		pause_until_done();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (grants_due.size() != 0)
			report_error($sformatf("%0d results never arrived", grants_due.size()));
		if (error_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
sv/pfa_pkg.sv
sv/pfa_regs.sv
sv/pfa_ctrl.sv
sv/pfa_dp.sv
sv/partition_fit_allocator_unit.sv
sv/pfa_checker.sv
sim/tb.sv
